FILE: sv/lpa_pkg.sv
// shared types and constants for the lifo page allocator
package lpa_pkg;

   // fixed field widths
   localparam int ADDR_BITS     = 32;
   localparam int CNT_BITS      = 16;
   localparam int KIND_BITS     = 3;
   localparam int STATUS_BITS   = 2;
   localparam int CSR_IDX_BITS  = 2;
   localparam int RSP_DATA_BITS = 56;

   // request kinds, carried on tuser
   typedef enum logic [KIND_BITS-1:0] {
      KIND_INIT     = 3'd0,
      KIND_FREE     = 3'd1,
      KIND_ALLOC    = 3'd2,
      KIND_USER_INC = 3'd3,
      KIND_USER_DEC = 3'd4
   } kind_type;

   // result status codes
   typedef enum logic [STATUS_BITS-1:0] {
      STATUS_OK       = 2'd0,
      STATUS_EMPTY    = 2'd1,
      STATUS_BAD_ADDR = 2'd2,
      STATUS_OVERFLOW = 2'd3
   } status_type;

   // configuration register indexes
   typedef enum logic [CSR_IDX_BITS-1:0] {
      CSR_KERNEL_END = 2'd0,
      CSR_PHYS_TOP   = 2'd1,
      CSR_MAX_USER   = 2'd2
   } csr_idx_type;

   // sequencer states
   typedef enum logic {
      FSM_IDLE = 1'b0,
      FSM_POP  = 1'b1
   } fsm_state_type;

   // reset values of the configuration registers
   localparam logic [ADDR_BITS-1:0] KERNEL_END_RST = 32'h8010_0000;
   localparam logic [ADDR_BITS-1:0] PHYS_TOP_RST   = 32'h8800_0000;
   localparam logic [CNT_BITS-1:0]  MAX_USER_RST   = 16'd1024;

endpackage

FILE: sv/lifo_page_allocator_with_user_quota.sv
// lifo page-frame allocator with freed-page stack memory and user page quota counter
// result path: each result goes to the result register; an allocation served from the
//   freed-page stack first passes through the synchronous memory read register
// throughput: one item per cycle while results drain; stack pops stall new requests
// reset: clears stack fill, fresh pointer, user count, sequencer and result valid;
//   configuration returns to its defaults; stack memory is not cleared
module lifo_page_allocator_with_user_quota #(
   parameter int PAGE_SHIFT  = 12,
   parameter int STACK_DEPTH = 32768,
   parameter int ADDR_WIDTH  = 32
) (
   input  logic                                 clock,
   input  logic                                 reset,
   // request channel
   input  logic                                 req_tvalid,
   output logic                                 req_tready,
   input  logic [lpa_pkg::ADDR_BITS-1:0]        req_tdata,   // [31:0] free_addr
   input  logic [lpa_pkg::KIND_BITS-1:0]        req_tuser,   // [2:0] kind
   // result channel
   output logic                                 rsp_tvalid,
   input  logic                                 rsp_tready,
   // [1:0] status, [33:2] page_addr, [34] user_can_alloc, [50:35] user_page_count
   output logic [lpa_pkg::RSP_DATA_BITS-1:0]    rsp_tdata,
   // configuration write port
   input  logic                                 csr_we,
   input  logic [lpa_pkg::CSR_IDX_BITS-1:0]     csr_addr,
   input  logic [lpa_pkg::ADDR_BITS-1:0]        csr_wdata
);

   // derived sizes
   localparam int AB   = lpa_pkg::ADDR_BITS;
   localparam int CB   = lpa_pkg::CNT_BITS;
   localparam int AW   = (ADDR_WIDTH < AB) ? ADDR_WIDTH : AB;
   localparam int SPW  = AW - PAGE_SHIFT;
   localparam int FPW  = AB - PAGE_SHIFT;
   localparam int FLW  = AB + 1 - PAGE_SHIFT;
   localparam int IW   = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
   localparam int FW   = $clog2(STACK_DEPTH + 1);
   localparam logic [AB-1:0] FREE_MASK = {AB{1'b1}} >> (AB - AW);
   localparam logic [FW-1:0] DEPTH_FILL = FW'(STACK_DEPTH);
   localparam logic [CB-1:0] CNT_MAX = {CB{1'b1}};

   // configuration registers
   logic [AB-1:0] kernel_end_ff;
   logic [AB-1:0] phys_top_ff;
   logic [CB-1:0] max_user_ff;

   // allocator state
   logic [FW-1:0]  fill_ff,  fill_in;
   logic [FPW-1:0] fresh_ff, fresh_in;
   logic [CB-1:0]  count_ff, count_in;
   lpa_pkg::fsm_state_type state_ff, state_in;

   // result register
   logic                       rsp_valid_ff, rsp_valid_in;
   lpa_pkg::status_type        rsp_status_ff, rsp_status_in;
   logic [AB-1:0]              rsp_page_ff, rsp_page_in;
   logic                       rsp_can_ff, rsp_can_in;
   logic [CB-1:0]              rsp_count_ff, rsp_count_in;

   // stack memory
   logic [SPW-1:0] stack_mem [STACK_DEPTH];
   logic [SPW-1:0] rd_data_ff;
   logic           mem_we;
   logic           mem_re;
   logic [IW-1:0]  wr_idx;
   logic [IW-1:0]  rd_idx;
   logic [SPW-1:0] push_page;

   // request decode helpers
   logic           req_fire;
   logic           pop_start;
   logic [AB-1:0]  free_addr_m;
   logic           free_bad;
   logic [FW-1:0]  fill_dec;
   logic [AB:0]    low_sum;
   logic [FLW-1:0] fresh_low;
   logic           fresh_avail;
   logic [FPW-1:0] fresh_dec;

   assign req_fire    = req_tvalid && req_tready;
   assign free_addr_m = req_tdata & FREE_MASK;
   assign free_bad    = (free_addr_m[PAGE_SHIFT-1:0] != '0)
                        || (free_addr_m < kernel_end_ff)
                        || (free_addr_m >= phys_top_ff);
   assign fill_dec    = fill_ff - 1'b1;
   assign low_sum     = {1'b0, kernel_end_ff} + (AB+1)'({PAGE_SHIFT{1'b1}});
   assign fresh_low   = low_sum[AB:PAGE_SHIFT];
   assign fresh_avail = {1'b0, fresh_ff} > fresh_low;
   assign fresh_dec   = fresh_ff - 1'b1;
   assign pop_start   = req_fire && (req_tuser == lpa_pkg::KIND_ALLOC) && (fill_ff != '0);
   assign wr_idx      = fill_ff[IW-1:0];
   assign rd_idx      = fill_dec[IW-1:0];
   assign push_page   = free_addr_m[AW-1:PAGE_SHIFT];

   // configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         kernel_end_ff <= lpa_pkg::KERNEL_END_RST;
         phys_top_ff   <= lpa_pkg::PHYS_TOP_RST;
         max_user_ff   <= lpa_pkg::MAX_USER_RST;
      end else if (csr_we) begin
         unique case (csr_addr)
            lpa_pkg::CSR_KERNEL_END: kernel_end_ff <= csr_wdata;
            lpa_pkg::CSR_PHYS_TOP:   phys_top_ff   <= csr_wdata;
            lpa_pkg::CSR_MAX_USER:   max_user_ff   <= csr_wdata[CB-1:0];
            default: ;
         endcase
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         lpa_pkg::FSM_IDLE: if (pop_start) state_in = lpa_pkg::FSM_POP;
         lpa_pkg::FSM_POP:  state_in = lpa_pkg::FSM_IDLE;
         default:           state_in = lpa_pkg::FSM_IDLE;
      endcase
   end

   // handshake outputs
   always_comb begin
      req_tready = (state_ff == lpa_pkg::FSM_IDLE) && (!rsp_valid_ff || rsp_tready);
      rsp_tvalid = rsp_valid_ff;
      rsp_tdata  = {{(lpa_pkg::RSP_DATA_BITS - 2 - AB - 1 - CB){1'b0}},
                    rsp_count_ff, rsp_can_ff, rsp_page_ff, rsp_status_ff};
   end

   // item processing and result formation
   always_comb begin
      fill_in       = fill_ff;
      fresh_in      = fresh_ff;
      count_in      = count_ff;
      mem_we        = 1'b0;
      mem_re        = 1'b0;
      rsp_valid_in  = rsp_valid_ff && !rsp_tready;
      rsp_status_in = rsp_status_ff;
      rsp_page_in   = rsp_page_ff;
      rsp_can_in    = rsp_can_ff;
      rsp_count_in  = rsp_count_ff;

      if (state_ff == lpa_pkg::FSM_POP) begin
         // popped page arrives from memory
         rsp_valid_in  = 1'b1;
         rsp_status_in = lpa_pkg::STATUS_OK;
         rsp_page_in   = AB'({rd_data_ff, {PAGE_SHIFT{1'b0}}});
         rsp_count_in  = count_ff;
         rsp_can_in    = count_ff < max_user_ff;
      end else if (req_fire) begin
         rsp_status_in = lpa_pkg::STATUS_OK;
         rsp_page_in   = '0;
         unique case (req_tuser)
            lpa_pkg::KIND_INIT: begin
               fill_in  = '0;
               count_in = '0;
               fresh_in = phys_top_ff[AB-1:PAGE_SHIFT];
            end
            lpa_pkg::KIND_FREE: begin
               if (free_bad) begin
                  rsp_status_in = lpa_pkg::STATUS_BAD_ADDR;
               end else if (fill_ff >= DEPTH_FILL) begin
                  rsp_status_in = lpa_pkg::STATUS_OVERFLOW;
               end else begin
                  mem_we  = 1'b1;
                  fill_in = fill_ff + 1'b1;
               end
            end
            lpa_pkg::KIND_ALLOC: begin
               if (fill_ff != '0) begin
                  mem_re  = 1'b1;
                  fill_in = fill_dec;
               end else if (fresh_avail) begin
                  fresh_in    = fresh_dec;
                  rsp_page_in = {fresh_dec, {PAGE_SHIFT{1'b0}}};
               end else begin
                  rsp_status_in = lpa_pkg::STATUS_EMPTY;
               end
            end
            lpa_pkg::KIND_USER_INC: begin
               if (count_ff != CNT_MAX) count_in = count_ff + 1'b1;
            end
            lpa_pkg::KIND_USER_DEC: begin
               if (count_ff != '0) count_in = count_ff - 1'b1;
            end
            default: ;
         endcase
         // stack pops deliver their beat in the next cycle, from the pop state
         rsp_valid_in = !pop_start;
         rsp_count_in = count_in;
         rsp_can_in   = count_in < max_user_ff;
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= lpa_pkg::FSM_IDLE;
         fill_ff      <= '0;
         fresh_ff     <= '0;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         fill_ff      <= fill_in;
         fresh_ff     <= fresh_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // result payload
   always_ff @(posedge clock) begin
      rsp_status_ff <= rsp_status_in;
      rsp_page_ff   <= rsp_page_in;
      rsp_can_ff    <= rsp_can_in;
      rsp_count_ff  <= rsp_count_in;
   end

   // freed-page stack, one write or one read per cycle
   always_ff @(posedge clock) begin
      if (mem_we) stack_mem[wr_idx] <= push_page;
      if (mem_re) rd_data_ff <= stack_mem[rd_idx];
   end

   // fill count stays within the stack
   a_fill_bound: assert property (@(posedge clock) disable iff (reset)
      fill_ff <= DEPTH_FILL)
      else $error("stack fill beyond depth");

   // the result register is free when popped data returns
   a_pop_slot: assert property (@(posedge clock) disable iff (reset)
      state_ff == lpa_pkg::FSM_POP |-> !rsp_valid_ff)
      else $error("pop data would overwrite a pending result");

   // a stack pop is followed by its result beat
   a_pop_result: assert property (@(posedge clock) disable iff (reset)
      pop_start |=> ##1 (rsp_valid_ff && rsp_status_ff == lpa_pkg::STATUS_OK))
      else $error("stack pop gave no ok result");

   // no page address accompanies a failed item
   a_fail_no_page: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_status_ff != lpa_pkg::STATUS_OK) |-> rsp_page_ff == '0)
      else $error("page address on failed result");

   // no request is taken while a pop is in flight
   a_pop_stall: assert property (@(posedge clock) disable iff (reset)
      state_ff == lpa_pkg::FSM_POP |-> !req_tready)
      else $error("request taken during pop");

endmodule
